// ----- sv/gmas_pkg.sv -----
// ----------------------------------------------------------------------------
// gmas_pkg
// Shared widths, register indexes and control types of the gyro moving
// average scaler.
// ----------------------------------------------------------------------------
package gmas_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 16;
    localparam int RATE_W     = 32;
    localparam int BIAS_W     = 12;
    localparam int SCALE_W    = 16;

    // Running sum holds WINDOW samples for any window up to 16
    localparam int SUM_W      = 21;
    localparam int MAG_W      = SUM_W - 1;

    localparam int NUM_AXES   = 3;
    localparam int NUM_STAGES = 6;

    localparam int WINDOW_DEFAULT = 10;

    // Stream widths
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 144;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BIAS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 8'd1;

    localparam logic signed [BIAS_W-1:0] BIAS_RESET  = 12'sd12;
    localparam logic [SCALE_W-1:0]       SCALE_RESET = 16'd2562;

    // Stage load strobes, bit i loads pipeline stage i (bit 0 takes the item)
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } ctrl_t;

endpackage

// ----- sv/gmas_ctrl.sv -----
// ----------------------------------------------------------------------------
// gmas_ctrl
// Valid bits and per-stage ready chain of the pipeline, plus the shared
// ring write slot.
// ----------------------------------------------------------------------------
module gmas_ctrl #(
    parameter int WINDOW = gmas_pkg::WINDOW_DEFAULT,
    parameter int SLOT_W = $clog2(WINDOW)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [SLOT_W-1:0] slot,
    output gmas_pkg::ctrl_t   ctrl
);
    import gmas_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] rdy;
    logic [NUM_STAGES-1:0] drain;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;

    // Ready ripples back from the output: a stage takes data when empty
    // or when its content moves on in the same cycle
    always_comb
    begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    // Load strobes and valid update
    always_comb
    begin
        ctrl.load[0] = s_tvalid && rdy[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            ctrl.load[i] = valid_reg[i-1] && rdy[i];
        end
        for (int i = 0; i < NUM_STAGES - 1; i++)
        begin
            drain[i] = ctrl.load[i+1];
        end
        drain[NUM_STAGES-1] = m_tready;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            valid_next[i] = ctrl.load[i] || (valid_reg[i] && !drain[i]);
        end
    end

    // Advance the write slot once per accepted item, wrap at the window end
    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.load[0])
        begin
            if (slot_reg == SLOT_W'(WINDOW - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign slot     = slot_reg;

endmodule

// ----- sv/gmas_lane.sv -----
// ----------------------------------------------------------------------------
// gmas_lane
// One axis: sample ring and running sum, divide by the window through a
// reciprocal multiply, bias subtract with saturation, and scale multiply.
// ----------------------------------------------------------------------------
module gmas_lane #(
    parameter int WINDOW = gmas_pkg::WINDOW_DEFAULT,
    parameter int SLOT_W = $clog2(WINDOW)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gmas_pkg::ctrl_t                       ctrl,
    input  logic [SLOT_W-1:0]                     slot,
    input  logic signed [gmas_pkg::SAMPLE_W-1:0]  sample,
    input  logic signed [gmas_pkg::BIAS_W-1:0]    bias,
    input  logic [gmas_pkg::SCALE_W-1:0]          scale,
    output logic signed [gmas_pkg::AVG_W-1:0]     avg,
    output logic signed [gmas_pkg::RATE_W-1:0]    prod
);
    import gmas_pkg::*;

    // Reciprocal of the window, floor(2^MAG_W / WINDOW); the estimate it
    // gives is low by at most one
    localparam logic [MAG_W-1:0] RECIP = MAG_W'((1 << MAG_W) / WINDOW);
    localparam logic [MAG_W-1:0] WIN_M = MAG_W'(WINDOW);
    localparam logic signed [SUM_W:0] AVG_MAX = (SUM_W+1)'(2 ** (AVG_W - 1) - 1);
    localparam logic signed [SUM_W:0] AVG_MIN = -(SUM_W+1)'(2 ** (AVG_W - 1));
    localparam int PROD_W = AVG_W + SCALE_W + 1;

    logic signed [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;

    logic signed [SUM_W-1:0]    s1_sum_reg;
    logic                       s2_neg_reg;
    logic [MAG_W-1:0]           s2_mag_reg;
    logic [MAG_W-1:0]           s2_qest_reg;
    logic signed [SUM_W-1:0]    s3_quot_reg;
    logic signed [AVG_W-1:0]    s4_avg_reg;
    logic signed [AVG_W-1:0]    s5_avg_reg;
    logic signed [RATE_W-1:0]   s5_prod_reg;

    logic [SUM_W-1:0]           abs_sum;
    logic [MAG_W-1:0]           mag;
    logic [2*MAG_W-1:0]         est_prod;
    logic [MAG_W-1:0]           q_times_w;
    logic [MAG_W-1:0]           rem;
    logic [MAG_W-1:0]           q_fix;
    logic signed [SUM_W-1:0]    quot_next;
    logic signed [SUM_W:0]      diff;
    logic signed [AVG_W-1:0]    avg_next;
    logic signed [PROD_W-1:0]   prod_full;

    // Replace the oldest sample in the running sum
    assign sum_next = sum_reg - SUM_W'(ring_reg[slot]) + SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (ctrl.load[0])
        begin
            ring_reg[slot] <= sample;
            sum_reg        <= sum_next;
        end
    end

    // Magnitude times reciprocal gives the quotient estimate
    assign abs_sum  = s1_sum_reg[SUM_W-1] ? SUM_W'(-s1_sum_reg) : SUM_W'(s1_sum_reg);
    assign mag      = abs_sum[MAG_W-1:0];
    assign est_prod = (2*MAG_W)'(mag) * (2*MAG_W)'(RECIP);

    // Correct the estimate by one and restore the sign (truncate toward zero)
    assign q_times_w = MAG_W'(s2_qest_reg * WIN_M);
    assign rem       = s2_mag_reg - q_times_w;
    assign q_fix     = (rem >= WIN_M) ? s2_qest_reg + 1'b1 : s2_qest_reg;
    assign quot_next = s2_neg_reg ? -$signed(SUM_W'(q_fix)) : $signed(SUM_W'(q_fix));

    // Subtract the bias and clamp to the average range
    assign diff = (SUM_W+1)'(s3_quot_reg) - (SUM_W+1)'(bias);

    always_comb
    begin
        if (diff > AVG_MAX)
        begin
            avg_next = AVG_W'(AVG_MAX);
        end
        else if (diff < AVG_MIN)
        begin
            avg_next = AVG_W'(AVG_MIN);
        end
        else
        begin
            avg_next = AVG_W'(diff);
        end
    end

    // Signed average times unsigned scale
    assign prod_full = PROD_W'(s4_avg_reg) * $signed(PROD_W'(scale));

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_sum_reg <= sum_next;
        end
        if (ctrl.load[1])
        begin
            s2_neg_reg  <= s1_sum_reg[SUM_W-1];
            s2_mag_reg  <= mag;
            s2_qest_reg <= est_prod[2*MAG_W-1:MAG_W];
        end
        if (ctrl.load[2])
        begin
            s3_quot_reg <= quot_next;
        end
        if (ctrl.load[3])
        begin
            s4_avg_reg <= avg_next;
        end
        if (ctrl.load[4])
        begin
            s5_avg_reg  <= s4_avg_reg;
            s5_prod_reg <= prod_full[RATE_W-1:0];
        end
    end

    assign avg  = s5_avg_reg;
    assign prod = s5_prod_reg;

endmodule

// ----- sv/gmas_merge.sv -----
// ----------------------------------------------------------------------------
// gmas_merge
// Output stage: reorders the lane rates for board mounting and holds the
// packed result item until it is taken.
// ----------------------------------------------------------------------------
module gmas_merge (
    input  logic                                   clk,
    input  gmas_pkg::ctrl_t                        ctrl,
    input  logic signed [gmas_pkg::AVG_W-1:0]      avg_x,
    input  logic signed [gmas_pkg::AVG_W-1:0]      avg_y,
    input  logic signed [gmas_pkg::AVG_W-1:0]      avg_z,
    input  logic signed [gmas_pkg::RATE_W-1:0]     prod_x,
    input  logic signed [gmas_pkg::RATE_W-1:0]     prod_y,
    input  logic signed [gmas_pkg::RATE_W-1:0]     prod_z,
    output logic [gmas_pkg::M_DATA_W-1:0]          m_tdata
);
    import gmas_pkg::*;

    logic [M_DATA_W-1:0] data_reg;
    logic [RATE_W-1:0]   rate_x;

    // x rate is the negated y product
    assign rate_x = RATE_W'(0) - RATE_W'(prod_y);

    // Hold the result until the output stage reloads
    always_ff @(posedge clk)
    begin
        if (ctrl.load[NUM_STAGES-1])
        begin
            data_reg <= {prod_z, prod_x, rate_x, avg_z, avg_y, avg_x};
        end
    end

    assign m_tdata = data_reg;

endmodule

// ----- sv/gyro_moving_average_scaler.sv -----
// ----------------------------------------------------------------------------
// gyro_moving_average_scaler
// Three-axis moving average over WINDOW samples, bias removal with
// saturation, and scaling to 2^-24 rad/s with axis reordering.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: raw_x, raw_y, raw_z
// m_*       out  m_tvalid/m_tready    m_tdata: avg_x/y/z, rate_x/y/z
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (0 bias, 1 scale)
//
// One item per cycle sustained while m_tready stays high; each item passes
// through the six-stage lane pipeline (sum, reciprocal multiply,
// correction, bias clamp, scale multiply, output register).
// Reset clears the sample rings, sums, write slot and all valid bits at
// once; bias and scale return to their defaults.
// Each stage holds under a stall and takes a new item as soon as its
// content moves on, so bubbles close up while the output waits.
// ----------------------------------------------------------------------------
module gyro_moving_average_scaler #(
    parameter int WINDOW = gmas_pkg::WINDOW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: raw_x [15:0], raw_y [31:16], raw_z [47:32]
    input  logic [gmas_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: avg_x [15:0], avg_y [31:16], avg_z [47:32],
    //          rate_x [79:48], rate_y [111:80], rate_z [143:112]
    output logic [gmas_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gmas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gmas_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gmas_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);

    ctrl_t                    ctrl;
    logic [SLOT_W-1:0]        slot;
    logic signed [BIAS_W-1:0] bias_reg;
    logic [SCALE_W-1:0]       scale_reg;

    logic signed [AVG_W-1:0]  avg [NUM_AXES];
    logic signed [RATE_W-1:0] prod [NUM_AXES];

    // Configuration registers, writes to unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg  <= BIAS_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BIAS:  bias_reg  <= $signed(cfg_data[BIAS_W-1:0]);
                REG_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                default:   ;
            endcase
        end
    end

    gmas_ctrl #(
        .WINDOW (WINDOW),
        .SLOT_W (SLOT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .slot     (slot),
        .ctrl     (ctrl)
    );

    // One lane per axis
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        gmas_lane #(
            .WINDOW (WINDOW),
            .SLOT_W (SLOT_W)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .slot   (slot),
            .sample ($signed(s_tdata[a*SAMPLE_W +: SAMPLE_W])),
            .bias   (bias_reg),
            .scale  (scale_reg),
            .avg    (avg[a]),
            .prod   (prod[a])
        );
    end

    gmas_merge u_merge (
        .clk     (clk),
        .ctrl    (ctrl),
        .avg_x   (avg[0]),
        .avg_y   (avg[1]),
        .avg_z   (avg[2]),
        .prod_x  (prod[0]),
        .prod_y  (prod[1]),
        .prod_z  (prod[2]),
        .m_tdata (m_tdata)
    );

endmodule

// ----- sv/gmas_checker.sv -----
// ----------------------------------------------------------------------------
// gmas_checker
// Port-level checks of the gyro moving average scaler: output hold under
// stall, item accounting and configuration acceptance.
// ----------------------------------------------------------------------------
module gmas_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [gmas_pkg::M_DATA_W-1:0]     m_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic                              cfg_valid,
    input logic                              cfg_ready
);
    import gmas_pkg::*;

    logic [3:0] inflight_reg;
    logic [3:0] inflight_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Count items taken but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Stalled result stays presented
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Stalled result keeps its data
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // No result without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> inflight_reg != 4'd0)
        else $error("result without a pending item");

    // Never more items in flight than pipeline stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(NUM_STAGES))
        else $error("more items in flight than stages");

    // Configuration writes are always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind gyro_moving_average_scaler gmas_checker u_gmas_checker (.*);

// ----- test/gmas_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmas_tb_pkg
// Scoreboard for the gyro moving average scaler testbench. It keeps its own
// sample rings, running sums and register copies, predicts the averages and
// rates of every accepted item, and checks the results in order.
// ----------------------------------------------------------------------------
package gmas_tb_pkg;

    import gmas_pkg::*;

    // Result layout, last field in the lowest bits of m_tdata
    typedef struct packed {
        logic [RATE_W-1:0] rate_z;
        logic [RATE_W-1:0] rate_y;
        logic [RATE_W-1:0] rate_x;
        logic [AVG_W-1:0]  avg_z;
        logic [AVG_W-1:0]  avg_y;
        logic [AVG_W-1:0]  avg_x;
    } filter_out_t;

    localparam int MAX_PRINTED = 20;

    class gyro_filter_scoreboard;

        logic signed [SAMPLE_W-1:0] ring [NUM_AXES][WINDOW_DEFAULT];
        int                         sum [NUM_AXES];
        int                         slot;
        logic signed [BIAS_W-1:0]   bias;
        logic [SCALE_W-1:0]         scale;
        filter_out_t                expected_q [$];
        int                         mismatches;
        int                         samples_in;
        int                         results_checked;
        int                         clamps_high;
        int                         clamps_low;

        function new();
            foreach (ring[a, i])
                ring[a][i] = '0;
            foreach (sum[a])
                sum[a] = 0;
            slot            = 0;
            bias            = BIAS_RESET;
            scale           = SCALE_RESET;
            mismatches      = 0;
            samples_in      = 0;
            results_checked = 0;
            clamps_high     = 0;
            clamps_low      = 0;
        endfunction

        // Mirror a register write; unmapped indexes change nothing
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_BIAS)
                bias = data[BIAS_W-1:0];
            else if (idx == REG_SCALE)
                scale = data[SCALE_W-1:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Replace the oldest sample, average, remove bias and clamp to 16 bits
        function int push_average(int axis, logic signed [SAMPLE_W-1:0] sample);
            int avg;
            sum[axis] = sum[axis] - int'(ring[axis][slot]) + int'(sample);
            ring[axis][slot] = sample;
            avg = sum[axis] / WINDOW_DEFAULT - int'(bias);
            if (avg > 32767)
            begin
                avg = 32767;
                clamps_high++;
            end
            if (avg < -32768)
            begin
                avg = -32768;
                clamps_low++;
            end
            return avg;
        endfunction

        // Predict the result of one accepted item
        function void note_sample(logic [S_DATA_W-1:0] data);
            int                         avg [NUM_AXES];
            logic signed [SAMPLE_W-1:0] sample;
            longint                     gain;
            longint                     prod;
            filter_out_t                want;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sample = data[SAMPLE_W*a +: SAMPLE_W];
                avg[a] = push_average(a, sample);
            end
            slot = (slot + 1 == WINDOW_DEFAULT) ? 0 : slot + 1;
            gain = longint'(scale);
            want.avg_x  = avg[0][AVG_W-1:0];
            want.avg_y  = avg[1][AVG_W-1:0];
            want.avg_z  = avg[2][AVG_W-1:0];
            // Board mounting: x takes -y, y takes x
            prod = -(longint'(avg[1]) * gain);
            want.rate_x = prod[RATE_W-1:0];
            prod = longint'(avg[0]) * gain;
            want.rate_y = prod[RATE_W-1:0];
            prod = longint'(avg[2]) * gain;
            want.rate_z = prod[RATE_W-1:0];
            expected_q.push_back(want);
            samples_in++;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("tb: mismatch at %0t: %s", $realtime, msg);
        endtask

        // Compare one output item with the oldest prediction, field by field
        task check_result(logic [M_DATA_W-1:0] data);
            filter_out_t got;
            filter_out_t want;
            logic [RATE_W-1:0] got_f [6];
            logic [RATE_W-1:0] want_f [6];
            string names [6] = '{"avg_x", "avg_y", "avg_z", "rate_x", "rate_y", "rate_z"};
            got = data;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing pending, data %h", data));
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            got_f  = '{RATE_W'(got.avg_x), RATE_W'(got.avg_y), RATE_W'(got.avg_z),
                       got.rate_x, got.rate_y, got.rate_z};
            want_f = '{RATE_W'(want.avg_x), RATE_W'(want.avg_y), RATE_W'(want.avg_z),
                       want.rate_x, want.rate_y, want.rate_z};
            for (int f = 0; f < 6; f++)
                if (got_f[f] !== want_f[f])
                    report($sformatf("result %0d %s got %h expected %h",
                                     results_checked, names[f], got_f[f], want_f[f]));
        endtask

    endclass

endpackage

// ----- test/gyro_moving_average_scaler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_moving_average_scaler_tb
// Streams three-axis gyro samples through the filter under several bias and
// scale settings, with random gaps on both sides and one long output stall,
// and checks every averaged and scaled result against a scoreboard.
// ----------------------------------------------------------------------------
module gyro_moving_average_scaler_tb;

    import gmas_pkg::*;
    import gmas_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int LONG_HOLD     = 120;
    localparam int DRAIN_CYCLES  = 12;
    localparam int PHASE_ITEMS   = 250;
    localparam int NUM_PHASES    = 6;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    gyro_filter_scoreboard sb = new();

    int cycles             = 0;
    int tx_gap_max         = 0;
    int rx_gap_max         = 0;
    int long_hold_requests = 0;
    int settings_used      = 0;

    gyro_moving_average_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // Accept output items, stall at random, and hold off once for a long stretch
    initial
    begin : result_sink
        int wait_left;
        int long_holds_done;
        wait_left       = 0;
        long_holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_tvalid && m_tready)
                begin
                    sb.check_result(m_tdata);
                    wait_left = $urandom_range(0, rx_gap_max);
                end
                if (long_holds_done < long_hold_requests)
                begin
                    wait_left = LONG_HOLD;
                    long_holds_done++;
                end
                if (wait_left > 0)
                begin
                    m_tready <= 1'b0;
                    wait_left--;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // Offer one item after a random gap; valid stays high for a back-to-back item
    task automatic send_sample(input logic [SAMPLE_W-1:0] x, y, z);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {z, y, x};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample({z, y, x});
    endtask

    // Write one register; the block is idle whenever this is called
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Bias word with junk in the bits above the register
    function automatic logic [CFG_DATA_W-1:0] bias_word(int b);
        logic [3:0] junk;
        junk = 4'($urandom());
        return {junk, b[BIAS_W-1:0]};
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] corners [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 3)];
        return SAMPLE_W'($urandom());
    endfunction

    // Sample near one rail, so a full window drives the average toward a clamp
    function automatic logic [SAMPLE_W-1:0] rail_sample(bit high);
        int v;
        v = high ? 32767 - $urandom_range(0, 300) : -32768 + $urandom_range(0, 300);
        return v[SAMPLE_W-1:0];
    endfunction

    initial
    begin : stimulus
        int  bias_set [NUM_PHASES]  = '{2047, -2048, 0, 12, 0, 0};
        int  scale_set [NUM_PHASES] = '{65535, 0, 1, 2562, 0, 0};
        int  tx_gaps [NUM_PHASES]   = '{9, 0, 9, 0, 9, 3};
        int  rx_gaps [NUM_PHASES]   = '{9, 0, 0, 9, 9, 3};
        int  sent;
        int  run_len;
        bit  rail_x, rail_y, rail_z;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start-up with reset defaults: the rings still hold zeros, y clamps low
        tx_gap_max = 2;
        rx_gap_max = 2;
        settings_used++;
        repeat (10) send_sample(16'h7FFF, 16'h8000, 16'hFFFF);
        send_sample(16'h0000, 16'h7FFF, 16'h8000);
        send_sample(16'hFFFF, 16'h0000, 16'h7FFF);
        drain();

        // Most negative bias with full scale: x clamps high; unmapped writes do nothing
        write_reg(REG_BIAS, 16'hF800);
        write_reg(REG_SCALE, 16'hFFFF);
        write_reg(REG_UNMAPPED_LO, 16'h1234);
        write_reg(REG_UNMAPPED_HI, 16'hFFFF);
        settings_used++;
        repeat (10) send_sample(16'h7FFF, 16'h8000, 16'h0000);
        drain();

        bias_set[4]  = $urandom_range(0, 4095) - 2048;
        bias_set[5]  = $urandom_range(0, 4095) - 2048;
        scale_set[4] = $urandom_range(0, 65535);
        scale_set[5] = $urandom_range(0, 65535);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_reg(REG_BIAS, bias_word(bias_set[phase]));
            write_reg(REG_SCALE, scale_set[phase][SCALE_W-1:0]);
            write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom()));
            settings_used++;
            tx_gap_max = tx_gaps[phase];
            rx_gap_max = rx_gaps[phase];
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // Fill the pipeline against a long output stall once
                if (phase == 1 && sent >= 40 && long_hold_requests == 0)
                    long_hold_requests++;
                if ($urandom_range(0, 3) == 0)
                begin
                    // Runs near the rails push the window average to the clamps
                    run_len = $urandom_range(10, 20);
                    rail_x  = 1'($urandom());
                    rail_y  = 1'($urandom());
                    rail_z  = 1'($urandom());
                    repeat (run_len)
                        send_sample(rail_sample(rail_x), rail_sample(rail_y),
                                    rail_sample(rail_z));
                end
                else
                begin
                    run_len = $urandom_range(1, 30);
                    repeat (run_len)
                        send_sample(random_sample(), random_sample(), random_sample());
                end
                sent += run_len;
            end
            drain();
        end

        $display("tb: %0d samples filtered, %0d results checked under %0d register settings",
                 sb.samples_in, sb.results_checked, settings_used);
        $display("tb: averages clamped high %0d times and low %0d times, %0d mismatches",
                 sb.clamps_high, sb.clamps_low, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
